/* hw/rtl/lpgs_pkg.sv */
// Shared types and constants of the LCD plane grey scaler.
// No dependencies; every other file of the block depends on this package.
package lpgs_pkg;

    // Default geometry and limits
    localparam int LPGS_SOURCE_ROWS   = 64;
    localparam int LPGS_BYTES_PER_ROW = 12;
    localparam int LPGS_MAX_SHADES    = 16;
    localparam int LPGS_MAX_SCALE     = 4;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int GREY_W   = 5;
    localparam int ROW_W    = 8;
    localparam int GROUP_W  = 6;
    localparam int SRC_ROW_W = 6;
    localparam int COL_W    = 4;
    localparam int PLANE_W  = 4;
    localparam int SHADE_W  = 5;
    localparam int SCALE_W  = 3;
    localparam int STEP_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHADE_COUNT = 2'd0,
        CFG_SCALE       = 2'd1
    } t_cfg_idx;

    // One finished byte handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0]               row_base;
        logic [GROUP_W-1:0]             group_base;
        logic [SCALE_W-1:0]             scale;
        logic [PIX_W-1:0][GREY_W-1:0]   counts;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hw/rtl/lpgs_in_if.sv */
// Input channel of the LCD plane grey scaler: one plane byte per item.
// Depends on lpgs_pkg.
interface lpgs_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpgs_pkg::PIX_W-1:0] pixel_bits;
    logic                      frame_start;

    modport source (output valid, pixel_bits, frame_start, input ready);
    modport sink   (input valid, pixel_bits, frame_start, output ready);
endinterface

/* hw/rtl/lpgs_out_if.sv */
// Output channel of the LCD plane grey scaler: one 8-pixel group per item.
// Depends on lpgs_pkg.
interface lpgs_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpgs_pkg::ROW_W-1:0]    out_row;
    logic [lpgs_pkg::GROUP_W-1:0]  out_group;
    logic [lpgs_pkg::GREY_W-1:0]   grey0;
    logic [lpgs_pkg::GREY_W-1:0]   grey1;
    logic [lpgs_pkg::GREY_W-1:0]   grey2;
    logic [lpgs_pkg::GREY_W-1:0]   grey3;
    logic [lpgs_pkg::GREY_W-1:0]   grey4;
    logic [lpgs_pkg::GREY_W-1:0]   grey5;
    logic [lpgs_pkg::GREY_W-1:0]   grey6;
    logic [lpgs_pkg::GREY_W-1:0]   grey7;
    logic                          burst_end;

    modport source (output valid, out_row, out_group, grey0, grey1, grey2, grey3,
                    grey4, grey5, grey6, grey7, burst_end, input ready);
    modport sink   (input valid, out_row, out_group, grey0, grey1, grey2, grey3,
                    grey4, grey5, grey6, grey7, burst_end, output ready);
endinterface

/* hw/rtl/lpgs_cfg_if.sv */
// Configuration write channel of the LCD plane grey scaler.
// Depends on lpgs_pkg.
interface lpgs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lpgs_pkg::CFG_IDX_W-1:0]   index;
    logic [lpgs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/lpgs_front.sv */
// Front end: accepts plane bytes, accumulates per-pixel counts and tracks
// plane, column and row. Depends on lpgs_pkg and lpgs_in_if.
module lpgs_front #(
    parameter int SOURCE_ROWS   = lpgs_pkg::LPGS_SOURCE_ROWS,
    parameter int BYTES_PER_ROW = lpgs_pkg::LPGS_BYTES_PER_ROW,
    parameter int MAX_SHADES    = lpgs_pkg::LPGS_MAX_SHADES,
    parameter int MAX_SCALE     = lpgs_pkg::LPGS_MAX_SCALE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpgs_in_if.sink                       i_in,
    input  logic [lpgs_pkg::SHADE_W-1:0]  i_shade_count,
    input  logic [lpgs_pkg::SCALE_W-1:0]  i_scale,
    input  lpgs_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output lpgs_pkg::t_job                o_job
);
    import lpgs_pkg::*;

    logic [PLANE_W-1:0]             r_plane, n_plane;
    logic [COL_W-1:0]               r_col, n_col;
    logic [SRC_ROW_W-1:0]           r_row, n_row;
    logic [PIX_W-1:0][GREY_W-1:0]   r_counts, n_counts;

    logic                   accept;
    logic                   last_plane;
    logic [PLANE_W-1:0]     plane;
    logic [COL_W-1:0]       col;
    logic [SRC_ROW_W-1:0]   row;
    logic [SHADE_W-1:0]     shades;
    logic [SCALE_W-1:0]     scale_eff;
    logic [SRC_ROW_W+SCALE_W-1:0] row_prod;
    logic [COL_W+SCALE_W-1:0]     col_prod;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    // Clamp the configured plane count and scale
    always_comb begin
        shades = i_shade_count;
        if (shades == '0) shades = SHADE_W'(1);
        if (shades > SHADE_W'(MAX_SHADES)) shades = SHADE_W'(MAX_SHADES);
        scale_eff = i_scale;
        if (scale_eff == '0) scale_eff = SCALE_W'(1);
        if (scale_eff > SCALE_W'(MAX_SCALE)) scale_eff = SCALE_W'(MAX_SCALE);
    end

    // Frame start clears the position before this byte is used
    assign plane = i_in.frame_start ? '0 : r_plane;
    assign col   = i_in.frame_start ? '0 : r_col;
    assign row   = i_in.frame_start ? '0 : r_row;

    assign last_plane = ({1'b0, plane} + SHADE_W'(1)) >= shades;

    assign row_prod = row * scale_eff;
    assign col_prod = col * scale_eff;

    always_comb begin
        n_counts = r_counts;
        n_plane  = r_plane;
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            for (int k = 0; k < PIX_W; k++) begin
                if (plane == '0) begin
                    n_counts[k] = GREY_W'(i_in.pixel_bits[PIX_W-1-k]);
                end else begin
                    n_counts[k] = r_counts[k] + GREY_W'(i_in.pixel_bits[PIX_W-1-k]);
                end
            end
            if (last_plane) begin
                n_plane = '0;
                if (({1'b0, col} + (COL_W+1)'(1)) >= (COL_W+1)'(BYTES_PER_ROW)) begin
                    n_col = '0;
                    if (({1'b0, row} + (SRC_ROW_W+1)'(1)) >= (SRC_ROW_W+1)'(SOURCE_ROWS)) begin
                        n_row = '0;
                    end else begin
                        n_row = row + SRC_ROW_W'(1);
                    end
                end else begin
                    n_col = col + COL_W'(1);
                    n_row = row;
                end
            end else begin
                n_plane = plane + PLANE_W'(1);
                n_col   = col;
                n_row   = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_counts <= '0;
        end else begin
            r_plane  <= n_plane;
            r_col    <= n_col;
            r_row    <= n_row;
            r_counts <= n_counts;
        end
    end

    assign o_push           = accept && last_plane;
    assign o_job.row_base   = row_prod[ROW_W-1:0];
    assign o_job.group_base = col_prod[GROUP_W-1:0];
    assign o_job.scale      = scale_eff;
    assign o_job.counts     = n_counts;

endmodule

/* hw/rtl/lpgs_queue.sv */
// Two-entry queue of finished bytes between front and back.
// Depends on lpgs_pkg.
module lpgs_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lpgs_pkg::t_job         i_job,
    input  logic                   i_pop,
    output lpgs_pkg::t_job         o_head,
    output lpgs_pkg::t_q_status    o_status
);
    import lpgs_pkg::*;

    t_job       r_entry [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_fill   = r_fill + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_job;
    end

    assign o_head         = r_entry[r_rd_ptr];
    assign o_status.full  = r_fill == 2'd2;
    assign o_status.empty = r_fill == 2'd0;

endmodule

/* hw/rtl/lpgs_back.sv */
// Back end: walks the scaled rows and groups of the head byte and drives
// the registered output channel. Depends on lpgs_pkg and lpgs_out_if.
module lpgs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpgs_pkg::t_job         i_head,
    input  lpgs_pkg::t_q_status    i_q_status,
    output logic                   o_pop,
    lpgs_out_if.source             o_out
);
    import lpgs_pkg::*;

    // Source pixel of output pixel p in group dx: (dx*8 + p) / scale
    function automatic logic [2:0] src_index(input logic [STEP_W-1:0] dx,
                                             input logic [2:0] p,
                                             input logic [SCALE_W-1:0] sc);
        logic [4:0]  v;
        logic [10:0] m;
        logic [4:0]  q;
        v = {dx, p};
        m = 11'(v) * 11'd43;
        case (sc)
            3'd2:    q = v >> 1;
            3'd3:    q = m[11-1:7] & 5'h1F;
            3'd4:    q = v >> 2;
            default: q = v;
        endcase
        return q[2:0];
    endfunction

    logic [STEP_W-1:0] r_dx, n_dx;
    logic [STEP_W-1:0] r_dy, n_dy;
    logic              r_valid, n_valid;
    logic              emit;
    logic              last_dx;
    logic              last_dy;
    logic [SCALE_W-1:0] sc_m1;

    logic [ROW_W-1:0]               r_row;
    logic [GROUP_W-1:0]             r_group;
    logic [PIX_W-1:0][GREY_W-1:0]   r_grey;
    logic                           r_end;

    assign sc_m1   = i_head.scale - SCALE_W'(1);
    assign last_dx = {1'b0, r_dx} == sc_m1;
    assign last_dy = {1'b0, r_dy} == sc_m1;
    assign emit    = !i_q_status.empty && (!r_valid || o_out.ready);
    assign o_pop   = emit && last_dx && last_dy;

    always_comb begin
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_valid = r_valid;
        if (o_out.ready) n_valid = 1'b0;
        if (emit) begin
            n_valid = 1'b1;
            if (last_dx) begin
                n_dx = '0;
                n_dy = last_dy ? '0 : r_dy + STEP_W'(1);
            end else begin
                n_dx = r_dx + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx    <= '0;
            r_dy    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_row   <= i_head.row_base + ROW_W'(r_dy);
            r_group <= i_head.group_base + GROUP_W'(r_dx);
            r_end   <= last_dx && last_dy;
            for (int p = 0; p < PIX_W; p++) begin
                r_grey[p] <= i_head.counts[src_index(r_dx, 3'(p), i_head.scale)];
            end
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_row   = r_row;
    assign o_out.out_group = r_group;
    assign o_out.grey0     = r_grey[0];
    assign o_out.grey1     = r_grey[1];
    assign o_out.grey2     = r_grey[2];
    assign o_out.grey3     = r_grey[3];
    assign o_out.grey4     = r_grey[4];
    assign o_out.grey5     = r_grey[5];
    assign o_out.grey6     = r_grey[6];
    assign o_out.grey7     = r_grey[7];
    assign o_out.burst_end = r_end;

endmodule

/* hw/rtl/lcd_plane_grey_scaler_core.sv */
// Top level of the LCD plane grey scaler: configuration registers, front,
// queue and back. Depends on lpgs_pkg, the channel interfaces and submodules.
//
// Usage:
//   i_in carries one monochrome plane byte per item (pixel_bits, bit 7 is
//   the leftmost pixel, and frame_start, which clears row, column and plane
//   before the byte). Planes of one byte position follow one another.
//   After the last plane of a byte, o_out delivers scale*scale items, scaled
//   row outer and 8-pixel group inner, each with eight grey levels; the last
//   item of the burst has burst_end set.
//   i_cfg writes shade_count (index 0) and scale (index 1); it is always
//   ready and must only be used while the block is idle.
// Timing:
//   A plane byte is taken whenever the queue is not full. A last plane is
//   written into the queue; the back end reads the queue head into the
//   registered output, one result per cycle while o_out is ready, so each
//   byte gives scale*scale results and the input, with shade_count planes
//   per byte, runs at the slower of the two sides.
//   A two-entry queue lets the front accept while the back drains a burst.
// Reset: synchronous, active low; clears counters, the queue and the output
//   valid, and loads shade_count 6 and scale 1.
// Stall: when o_out.ready is low the output register holds, the queue fills
//   and then i_in.ready drops until the back end moves again.
module lcd_plane_grey_scaler_core #(
    parameter int SOURCE_ROWS   = lpgs_pkg::LPGS_SOURCE_ROWS,
    parameter int BYTES_PER_ROW = lpgs_pkg::LPGS_BYTES_PER_ROW,
    parameter int MAX_SHADES    = lpgs_pkg::LPGS_MAX_SHADES,
    parameter int MAX_SCALE     = lpgs_pkg::LPGS_MAX_SCALE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpgs_in_if.sink     i_in,
    lpgs_out_if.source  o_out,
    lpgs_cfg_if.sink    i_cfg
);
    import lpgs_pkg::*;

    logic [SHADE_W-1:0] r_shade_count;
    logic [SCALE_W-1:0] r_scale;

    logic       q_push;
    logic       q_pop;
    t_job       q_job;
    t_job       q_head;
    t_q_status  q_status;

    // Configuration registers; writes to unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shade_count <= SHADE_W'(6);
            r_scale       <= SCALE_W'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SHADE_COUNT: r_shade_count <= i_cfg.data[SHADE_W-1:0];
                CFG_SCALE:       r_scale       <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: count planes and hand finished bytes to the queue
    lpgs_front #(
        .SOURCE_ROWS  (SOURCE_ROWS),
        .BYTES_PER_ROW(BYTES_PER_ROW),
        .MAX_SHADES   (MAX_SHADES),
        .MAX_SCALE    (MAX_SCALE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_shade_count(r_shade_count),
        .i_scale      (r_scale),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_job        (q_job)
    );

    // Queue: decouple plane intake from burst output
    lpgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_status(q_status)
    );

    // Back: expand the head byte into scaled results
    lpgs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_status(q_status),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (q_status.empty && !o_out.valid))
        else $error("queue or output not cleared by reset");
`endif

endmodule

/* dv/tb_lcd_plane_grey_scaler_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lcd_plane_grey_scaler_core: plane bytes in,
// scaled grey groups out.
// Depends on lpgs_pkg, lpgs_in_if, lpgs_out_if, lpgs_cfg_if and the core itself.
module tb_lcd_plane_grey_scaler_core;
    import lpgs_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;       // front and queue are done well within this
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 100;
    localparam int IDLE_MAX      = 14;
    localparam int LONG_HOLD     = 400;

    // Indexes the block has no register behind; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // One expected 8-pixel group of the upscaled image
    typedef struct packed {
        logic [ROW_W-1:0]             row;
        logic [GROUP_W-1:0]           group;
        logic [PIX_W-1:0][GREY_W-1:0] grey;
        logic                         last;
    } t_group_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpgs_in_if  in_ch ();
    lpgs_out_if out_ch ();
    lpgs_cfg_if cfg_ch ();

    lcd_plane_grey_scaler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror of the block: register copies and the per-pixel accumulator state
    logic [SHADE_W-1:0]   shade_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [GREY_W-1:0]    px_count [PIX_W];
    logic [PLANE_W-1:0]   plane_pos;
    logic [COL_W-1:0]     col_pos;
    logic [SRC_ROW_W-1:0] row_pos;

    // Groups predicted but not yet seen on the output, oldest first
    t_group_exp groups_due [$];

    int unsigned src_idle_max  = IDLE_MAX;
    int unsigned sink_idle_max = IDLE_MAX;
    bit          hold_req      = 1'b0;
    int unsigned hold_len      = 0;

    int unsigned planes_sent = 0;
    int unsigned groups_seen = 0;
    int unsigned reg_writes  = 0;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------
    // Grey accumulation and upscaling, one plane byte at a time
    // ------------------------------------------------------------------
    function automatic int unsigned shades_now();
        int unsigned s;
        s = shade_reg;
        if (s == 0) s = 1;
        if (s > LPGS_MAX_SHADES) s = LPGS_MAX_SHADES;
        return s;
    endfunction

    function automatic int unsigned scale_now();
        int unsigned s;
        s = scale_reg;
        if (s == 0) s = 1;
        if (s > LPGS_MAX_SCALE) s = LPGS_MAX_SCALE;
        return s;
    endfunction

    task automatic accumulate_plane(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned sh;
        int unsigned sc;
        int unsigned src;
        t_group_exp  g;
        sh = shades_now();
        sc = scale_now();
        // frame start drops the byte back to the frame origin first
        if (fs) begin
            row_pos   = '0;
            col_pos   = '0;
            plane_pos = '0;
        end
        // first plane replaces the counts, later planes add to them
        for (int k = 0; k < PIX_W; k++) begin
            if (plane_pos == '0) px_count[k] = {{(GREY_W-1){1'b0}}, pix[PIX_W-1-k]};
            else px_count[k] = px_count[k] + pix[PIX_W-1-k];
        end
        // not the last plane yet: just advance, nothing comes out
        if (int'(plane_pos) + 1 < sh) begin
            plane_pos = plane_pos + 1'b1;
            return;
        end
        // last plane (also when the count was lowered below the current plane)
        for (int unsigned dy = 0; dy < sc; dy++) begin
            for (int unsigned dx = 0; dx < sc; dx++) begin
                g.row   = ROW_W'(int'(row_pos) * sc + dy);
                g.group = GROUP_W'(int'(col_pos) * sc + dx);
                for (int unsigned p = 0; p < PIX_W; p++) begin
                    src = (dx * PIX_W + p) / sc;
                    g.grey[p] = px_count[src % PIX_W];
                end
                g.last = (dy == sc - 1) && (dx == sc - 1);
                groups_due.push_back(g);
            end
        end
        plane_pos = '0;
        // column wrap moves to the next row, row wrap back to the top
        if (int'(col_pos) + 1 >= LPGS_BYTES_PER_ROW) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= LPGS_SOURCE_ROWS) row_pos = '0;
            else row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one plane byte after a random gap; valid stays up on return so that
    // back-to-back items need no second assignment in one step.
    task automatic send_plane(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.pixel_bits  <= pix;
        in_ch.frame_start <= fs;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        accumulate_plane(pix, fs);
        planes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid after a run of items and step past that edge.
    task automatic stop_items();
        in_ch.valid       <= 1'b0;
        in_ch.frame_start <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every predicted group, then let the front finish any plain plane.
    task automatic drain_results();
        while (groups_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_SHADE_COUNT: shade_reg = val[SHADE_W-1:0];
            CFG_SCALE:       scale_reg = val[SCALE_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Output side: random stall before each item, plus one long hold on request.
    initial begin : result_sink
        int unsigned gap;
        int unsigned held;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                held = 0;
                while (held < hold_len) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            gap = $urandom_range(0, sink_idle_max);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            // hold ready until an item moves, or a hold is asked for
            do @(posedge i_clk); while (out_ch.valid !== 1'b1 && !hold_req);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string grey_text(input t_group_exp g);
        return $sformatf("%0d %0d %0d %0d %0d %0d %0d %0d", g.grey[0], g.grey[1],
                         g.grey[2], g.grey[3], g.grey[4], g.grey[5], g.grey[6],
                         g.grey[7]);
    endfunction

    task automatic note_fault(input string what, input bit has_want,
                              input t_group_exp want, input t_group_exp got);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            if (has_want)
                $display({"%0t %s: expected row %0d group %0d grey [%s] end %0b,",
                          " got row %0d group %0d grey [%s] end %0b"},
                         $time, what, want.row, want.group, grey_text(want), want.last,
                         got.row, got.group, grey_text(got), got.last);
            else
                $display("%0t %s: got row %0d group %0d grey [%s] end %0b",
                         $time, what, got.row, got.group, grey_text(got), got.last);
        end
    endtask

    always @(posedge i_clk) begin : group_check
        t_group_exp got;
        t_group_exp want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.row     = out_ch.out_row;
            got.group   = out_ch.out_group;
            got.grey[0] = out_ch.grey0;
            got.grey[1] = out_ch.grey1;
            got.grey[2] = out_ch.grey2;
            got.grey[3] = out_ch.grey3;
            got.grey[4] = out_ch.grey4;
            got.grey[5] = out_ch.grey5;
            got.grey[6] = out_ch.grey6;
            got.grey[7] = out_ch.grey7;
            got.last    = out_ch.burst_end;
            groups_seen++;
            if (groups_due.size() == 0) begin
                note_fault("unexpected group", 1'b0, '0, got);
            end else begin
                want = groups_due.pop_front();
                if (got.row !== want.row || got.group !== want.group ||
                    got.grey !== want.grey || got.last !== want.last)
                    note_fault("group mismatch", 1'b1, want, got);
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d groups still due", cycle_count,
                     groups_due.size());
            $display("lcd_plane_grey_scaler_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: six planes per byte at scale 1, counts start from the first plane.
    task automatic test_reset_defaults();
        send_plane(8'hFF, 1'b1);
        send_plane(8'h00, 1'b0);
        send_plane(8'h80, 1'b0);
        send_plane(8'h01, 1'b0);
        send_plane(8'hAA, 1'b0);
        send_plane(8'h55, 1'b0);
        stop_items();
        drain_results();
    endtask

    // Clamping of both registers, the full grey range and the spare indexes.
    task automatic test_register_limits();
        // over the top: 31 planes act as 16, scale 7 acts as 4; all ones reach grey 16
        write_reg(CFG_SHADE_COUNT, 8'hFF);
        write_reg(CFG_SCALE, 8'hFF);
        for (int i = 0; i < LPGS_MAX_SHADES; i++) send_plane(8'hFF, 1'b0);
        stop_items();
        drain_results();
        // zero in both registers acts as one; upper data bits must be dropped
        write_reg(CFG_SHADE_COUNT, 8'hE0);
        write_reg(CFG_SCALE, 8'hF8);
        write_reg(CFG_SPARE_LO, 8'h10);
        write_reg(CFG_SPARE_HI, 8'h03);
        send_plane(8'h00, 1'b0);
        send_plane(8'hFF, 1'b0);
        stop_items();
        drain_results();
    endtask

    // Shade count lowered to the plane already reached: the next plane closes the byte.
    task automatic test_shade_lowered();
        write_reg(CFG_SHADE_COUNT, 8'd6);
        write_reg(CFG_SCALE, 8'd2);
        send_plane(8'hF0, 1'b1);
        send_plane(8'h0F, 1'b0);
        send_plane(8'h3C, 1'b0);
        stop_items();
        drain_results();
        write_reg(CFG_SHADE_COUNT, 8'd3);
        send_plane(8'hC3, 1'b0);
        stop_items();
        drain_results();
    endtask

    // Frame start in the middle of a byte throws the partial counts away.
    task automatic test_frame_restart();
        write_reg(CFG_SHADE_COUNT, 8'd2);
        write_reg(CFG_SCALE, 8'd1);
        send_plane(8'hFF, 1'b1);
        send_plane(8'h81, 1'b0);
        send_plane(8'h7E, 1'b0);
        send_plane(8'h18, 1'b1);
        send_plane(8'h24, 1'b0);
        stop_items();
        drain_results();
    endtask

    // Long output hold with the input pushing hard: queue fills and input stalls.
    task automatic test_backpressure();
        write_reg(CFG_SHADE_COUNT, 8'd1);
        write_reg(CFG_SCALE, 8'd4);
        src_idle_max = 0;
        hold_len     = LONG_HOLD;
        hold_req     = 1'b1;
        for (int i = 0; i < 12; i++) send_plane(8'($urandom), 1'b0);
        stop_items();
        drain_results();
        src_idle_max = IDLE_MAX;
    endtask

    // Two source rows at scale 4: the column counter wraps into the next row
    // and the group numbers reach 47, the highest at this scale.
    task automatic test_column_wrap();
        write_reg(CFG_SHADE_COUNT, 8'd1);
        write_reg(CFG_SCALE, 8'd4);
        src_idle_max  = 2;
        sink_idle_max = 2;
        send_plane(8'($urandom), 1'b1);
        for (int b = 1; b < 2 * LPGS_BYTES_PER_ROW; b++)
            send_plane(8'($urandom), 1'b0);
        stop_items();
        drain_results();
        src_idle_max  = IDLE_MAX;
        sink_idle_max = IDLE_MAX;
    endtask

    function automatic int unsigned pick_idle_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return IDLE_MAX;
        endcase
    endfunction

    // Random setting per phase; small shade counts dominate to keep bursts frequent.
    task automatic pick_random_setting();
        int unsigned        roll;
        logic [SHADE_W-1:0] sh;
        roll = $urandom_range(0, 99);
        if (roll < 65)      sh = SHADE_W'($urandom_range(1, 4));
        else if (roll < 70) sh = '0;
        else if (roll < 90) sh = SHADE_W'($urandom_range(5, LPGS_MAX_SHADES));
        else                sh = SHADE_W'($urandom_range(LPGS_MAX_SHADES + 1, 31));
        write_reg(CFG_SHADE_COUNT, {3'($urandom), sh});
        write_reg(CFG_SCALE, {5'($urandom), 3'($urandom_range(0, 7))});
    endtask

    // Mostly complete bytes with random content; some frame restarts, mid-byte
    // restarts and bytes left unfinished across a setting change.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned nbytes;
        int unsigned sh;
        int unsigned planes;
        logic        fs;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick_random_setting();
            src_idle_max  = pick_idle_max();
            sink_idle_max = pick_idle_max();
            nbytes = $urandom_range(1, 8);
            sh     = shades_now();
            for (int unsigned b = 0; b < nbytes; b++) begin
                planes = sh;
                if (b == nbytes - 1 && sh > 1 && $urandom_range(0, 9) == 0)
                    planes = $urandom_range(1, sh - 1);
                for (int unsigned p = 0; p < planes; p++) begin
                    fs = 1'b0;
                    if (p == 0 && $urandom_range(0, 15) == 0) fs = 1'b1;
                    else if (p != 0 && $urandom_range(0, 24) == 0) fs = 1'b1;
                    send_plane(8'($urandom), fs);
                    sent++;
                end
            end
            stop_items();
            drain_results();
        end
        src_idle_max  = IDLE_MAX;
        sink_idle_max = IDLE_MAX;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        in_ch.valid       = 1'b0;
        in_ch.pixel_bits  = '0;
        in_ch.frame_start = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;

        // predictor starts from the reset state of the block
        shade_reg = SHADE_W'(6);
        scale_reg = SCALE_W'(1);
        for (int k = 0; k < PIX_W; k++) px_count[k] = '0;
        plane_pos = '0;
        col_pos   = '0;
        row_pos   = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_limits();
        test_shade_lowered();
        test_frame_restart();
        test_backpressure();
        test_column_wrap();
        test_random_frames();

        if (groups_due.size() != 0) begin
            fault_count++;
            $display("%0d expected groups never arrived", groups_due.size());
        end

        $display("Covered %0d plane items and %0d output groups over %0d register writes,",
                 planes_sent, groups_seen, reg_writes);
        $display("including column wraps at scale 4 and a %0d-cycle output hold; %0d faults.",
                 LONG_HOLD, fault_count);
        if (fault_count == 0) begin
            $display("lcd_plane_grey_scaler_core regression: pass");
        end else begin
            $display("lcd_plane_grey_scaler_core regression: fail");
        end
        $finish;
    end

endmodule
